@@ rtl/ptbl_pkg.sv @@
// shared types and constants for the peer table
package ptbl_pkg;

	localparam int IP_W     = 32;
	localparam int PORT_W   = 16;
	localparam int TIME_W   = 32;
	localparam int KEY_W    = IP_W + PORT_W;
	localparam int STATUS_W = 2;
	localparam int INDEX_W  = 4;
	localparam int OCC_W    = 5;
	localparam int LIMIT_W  = 5;

	// limit after reset, before saturation to the table depth
	localparam int LIMIT_RESET = 16;

	// result status codes
	localparam logic [STATUS_W-1:0] STATUS_REFRESHED = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;

	typedef struct packed {
		logic [IP_W-1:0]   peer_ip;
		logic [PORT_W-1:0] peer_port;
		logic [TIME_W-1:0] now_ms;
	} in_word_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [INDEX_W-1:0]  entry_index;
		logic [OCC_W-1:0]    occupancy;
	} out_word_t;

endpackage

@@ rtl/peer_table_insert_or_refresh_top.sv @@
// peer table: search for a peer key, refresh its time, append it, or report the table full
// a result is loaded once the scan reaches a hit or passes the occupied entries; a stalled
// result holds the commit, and the next word can be taken in the cycle after the result is
// loaded, so a new word is not taken until the previous word's result has been loaded
// reset clears the occupancy and sets the limit to min(16, TABLE_DEPTH); memories kept
module peer_table_insert_or_refresh_top #(
	parameter int TABLE_DEPTH = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  ptbl_pkg::in_word_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output ptbl_pkg::out_word_t            out_data,
	input  logic                           cfg_we,
	input  logic [ptbl_pkg::LIMIT_W-1:0]   cfg_data
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int LIMIT_RST = (TABLE_DEPTH < ptbl_pkg::LIMIT_RESET) ?
		TABLE_DEPTH : ptbl_pkg::LIMIT_RESET;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t              state_q;
	logic [CNT_W-1:0]    used_q;
	logic [CNT_W-1:0]    limit_q;
	logic [CNT_W-1:0]    rd_idx_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic                hit_q;
	logic [IDX_W-1:0]    hit_idx_q;
	logic                out_valid_q;
	ptbl_pkg::in_word_t  in_q;
	ptbl_pkg::out_word_t out_q;

	logic [ptbl_pkg::KEY_W-1:0]  key_q;
	logic [ptbl_pkg::KEY_W-1:0]  rd_key;
	logic [ptbl_pkg::TIME_W-1:0] rd_time;
	logic                        issue;
	logic                        match;
	logic                        commit_fire;
	logic                        do_insert;
	logic                        mem_we;
	logic                        key_we;
	logic [IDX_W-1:0]            waddr;
	logic [IDX_W-1:0]            raddr;
	logic [31:0]                 cfg_ext;
	logic [CNT_W-1:0]            limit_in;
	logic [CNT_W-1:0]            occ_nxt;
	logic [IDX_W-1:0]            idx_nxt;
	logic [31:0]                 occ_ext;
	logic [31:0]                 idx_ext;
	ptbl_pkg::out_word_t         out_nxt;

	assign key_q = {in_q.peer_ip, in_q.peer_port};

	// written limit saturates at the table depth
	assign cfg_ext  = 32'(cfg_data);
	assign limit_in = (cfg_ext > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : CNT_W'(cfg_ext);

	// scan: one read issued per cycle, each compared in the cycle after its read
	assign issue = (rd_idx_q < used_q);
	assign raddr = rd_idx_q[IDX_W-1:0];
	assign match = vld_s1 && (rd_key == key_q);

	// commit: decide, write back and load the result register
	assign commit_fire = (state_q == ST_COMMIT) && (!out_valid_q || out_ready);
	assign do_insert   = !hit_q && (used_q < limit_q);
	assign mem_we      = commit_fire && (hit_q || do_insert);
	assign key_we      = commit_fire && do_insert;
	assign waddr       = hit_q ? hit_idx_q : used_q[IDX_W-1:0];

	always_comb begin
		occ_nxt = used_q;
		idx_nxt = '0;
		out_nxt.status = ptbl_pkg::STATUS_FULL;
		if (hit_q) begin
			idx_nxt = hit_idx_q;
			out_nxt.status = ptbl_pkg::STATUS_REFRESHED;
		end else if (do_insert) begin
			idx_nxt = used_q[IDX_W-1:0];
			occ_nxt = used_q + CNT_W'(1);
			out_nxt.status = ptbl_pkg::STATUS_INSERTED;
		end
		occ_ext = 32'(occ_nxt);
		idx_ext = 32'(idx_nxt);
		out_nxt.entry_index = idx_ext[ptbl_pkg::INDEX_W-1:0];
		out_nxt.occupancy   = occ_ext[ptbl_pkg::OCC_W-1:0];
	end

	// key memory, read during the scan, written on insert
	ptbl_ram #(
		.WIDTH (ptbl_pkg::KEY_W),
		.DEPTH (TABLE_DEPTH)
	) u_key_ram (
		.clk   (clk),
		.we    (key_we),
		.waddr (waddr),
		.wdata (key_q),
		.raddr (raddr),
		.rdata (rd_key)
	);

	// last-seen time memory, written on refresh and insert
	ptbl_ram #(
		.WIDTH (ptbl_pkg::TIME_W),
		.DEPTH (TABLE_DEPTH)
	) u_time_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (waddr),
		.wdata (in_q.now_ms),
		.raddr (raddr),
		.rdata (rd_time)
	);

	// sequencer, occupancy, limit and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			used_q      <= '0;
			limit_q     <= CNT_W'(LIMIT_RST);
			rd_idx_q    <= '0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= limit_in;
			end
			if (out_valid_q && out_ready && !commit_fire) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q  <= ST_SCAN;
						rd_idx_q <= '0;
						vld_s1   <= 1'b0;
					end
				end
				ST_SCAN: begin
					priority if (match) begin
						state_q <= ST_COMMIT;
						hit_q   <= 1'b1;
						vld_s1  <= 1'b0;
					end else if (!issue && !vld_s1) begin
						state_q <= ST_COMMIT;
						hit_q   <= 1'b0;
					end else begin
						vld_s1 <= issue;
						if (issue) begin
							rd_idx_q <= rd_idx_q + CNT_W'(1);
						end
					end
				end
				ST_COMMIT: begin
					if (commit_fire) begin
						state_q     <= ST_IDLE;
						used_q      <= occ_nxt;
						out_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_q <= in_data;
		end
		if (state_q == ST_SCAN) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
			if (match) begin
				hit_idx_q <= idx_s1;
			end
		end
		if (commit_fire) begin
			out_q <= out_nxt;
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// occupancy never passes the table depth
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'(TABLE_DEPTH))
		else $error("occupancy beyond table depth");

	// a new result appears only out of a commit
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
		else $error("result without commit");

	// an insert grows the occupancy by exactly one
	a_insert_grow: assert property (@(posedge clk) disable iff (!arst_n)
		key_we |=> (used_q == $past(used_q) + CNT_W'(1)))
		else $error("insert did not grow occupancy");

	// a hit always points at an occupied entry
	a_hit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMMIT && hit_q) |-> (CNT_W'(hit_idx_q) < used_q))
		else $error("hit index outside occupied entries");

	// the scan read pointer never passes the occupancy
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_idx_q <= used_q))
		else $error("scan pointer past occupancy");

	// every occupied entry read by the scan holds a written time
	a_time_known: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && vld_s1) |-> !$isunknown(rd_time))
		else $error("occupied entry with unwritten time");

endmodule

@@ rtl/ptbl_ram.sv @@
// generic single write port ram with registered read
module ptbl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ sim/testbench.sv @@
// self-checking testbench for the peer table insert-or-refresh block
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import ptbl_pkg::*;

	localparam int          TABLE_DEPTH = 16;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned SETTLE      = TABLE_DEPTH + 8;
	localparam int unsigned HOLD_AFTER  = 400;
	localparam int unsigned HOLD_CYCLES = 300;

	// expected outcome of each accepted word, from a private copy of the table
	class peer_table_tracker;
		logic [KEY_W-1:0]  keys[];
		logic [TIME_W-1:0] seen[];
		int unsigned       depth;
		int unsigned       used;
		int unsigned       limit;
		int unsigned       accepted;
		int unsigned       errors;
		out_word_t         awaited_outcomes[$];

		function new(int unsigned d);
			depth    = d;
			keys     = new[d];
			seen     = new[d];
			used     = 0;
			accepted = 0;
			errors   = 0;
			limit    = (LIMIT_RESET > d) ? d : LIMIT_RESET;
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] v);
			limit = (v > depth) ? depth : v;
		endfunction

		function int unsigned pending();
			return awaited_outcomes.size();
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $time, msg);
			errors++;
		endtask

		// search occupied entries, refresh on a hit, append while below the limit
		function void note_word(in_word_t w);
			logic [KEY_W-1:0] key;
			out_word_t        res;
			bit               hit;
			int unsigned      i;
			key             = {w.peer_ip, w.peer_port};
			hit             = 1'b0;
			res.status      = STATUS_FULL;
			res.entry_index = '0;
			for (i = 0; i < used && i < depth; i++) begin
				if (!hit && keys[i] == key) begin
					seen[i]         = w.now_ms;
					res.status      = STATUS_REFRESHED;
					res.entry_index = i[INDEX_W-1:0];
					hit             = 1'b1;
				end
			end
			if (!hit && used < limit && used < depth) begin
				keys[used]      = key;
				seen[used]      = w.now_ms;
				res.status      = STATUS_INSERTED;
				res.entry_index = used[INDEX_W-1:0];
				used++;
			end
			res.occupancy = used[OCC_W-1:0];
			awaited_outcomes.push_back(res);
			accepted++;
		endfunction

		task check_word(out_word_t got);
			out_word_t want;
			if (awaited_outcomes.size() == 0) begin
				report_mismatch($sformatf("result word %h with nothing awaited", got));
			end else begin
				want = awaited_outcomes.pop_front();
				if (got.status !== want.status)
					report_mismatch($sformatf("status got %0d want %0d",
						got.status, want.status));
				if (got.entry_index !== want.entry_index)
					report_mismatch($sformatf("entry_index got %0d want %0d",
						got.entry_index, want.entry_index));
				if (got.occupancy !== want.occupancy)
					report_mismatch($sformatf("occupancy got %0d want %0d",
						got.occupancy, want.occupancy));
			end
		endtask
	endclass

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                in_valid  = 1'b0;
	logic                in_ready;
	in_word_t            in_data   = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	out_word_t           out_data;
	logic                cfg_we    = 1'b0;
	logic [LIMIT_W-1:0]  cfg_data  = '0;

	peer_table_tracker   tracker;
	bit                  calm      = 1'b0;
	int unsigned         cycles    = 0;

	peer_table_insert_or_refresh_top #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	// clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// result side: random stalls, one long hold-off, a calm stretch
	initial begin : result_sink
		int unsigned hold_left;
		bit          held;
		hold_left = 0;
		held      = 1'b0;
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready)
				tracker.check_word(out_data);
			if (!held && tracker != null && tracker.accepted >= HOLD_AFTER) begin
				held      = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(99) >= 11);
			end
		end
	end

	// offer one word, wait for it to be taken, then maybe leave a gap
	task automatic send_word(input in_word_t w);
		int unsigned gap;
		in_valid <= 1'b1;
		in_data  <= w;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		tracker.note_word(w);
		if (!calm && $urandom_range(99) < 11) begin
			gap = $urandom_range(24, 1);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_peer(input logic [IP_W-1:0] ip, input logic [PORT_W-1:0] port,
			input logic [TIME_W-1:0] t);
		in_word_t w;
		w.peer_ip   = ip;
		w.peer_port = port;
		w.now_ms    = t;
		send_word(w);
	endtask

	// limit is only written once the table has gone quiet
	task automatic set_peer_limit(input logic [LIMIT_W-1:0] v);
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		tracker.set_limit(v);
	endtask

	// known peers most often, some near misses, some all-ones or all-zero keys, the rest fresh keys
	function automatic in_word_t pick_word();
		int unsigned      roll;
		logic [KEY_W-1:0] key;
		logic [KEY_W-1:0] one;
		in_word_t         w;
		one  = {{(KEY_W-1){1'b0}}, 1'b1};
		roll = $urandom_range(99);
		if (tracker.used != 0 && roll < 45)
			key = tracker.keys[$urandom_range(tracker.used - 1)];
		else if (tracker.used != 0 && roll < 60)
			key = tracker.keys[$urandom_range(tracker.used - 1)]
				^ (one << $urandom_range(KEY_W - 1));
		else if (roll < 64)
			key = ($urandom_range(1) != 0) ? {KEY_W{1'b1}} : {KEY_W{1'b0}};
		else
			key = {$urandom, 16'($urandom)};
		w.peer_ip   = key[KEY_W-1:PORT_W];
		w.peer_port = key[PORT_W-1:0];
		w.now_ms    = $urandom;
		if (roll >= 94)
			w.now_ms = ($urandom_range(1) != 0) ? {TIME_W{1'b1}} : {TIME_W{1'b0}};
		return w;
	endfunction

	task automatic run_random(input int unsigned count);
		int unsigned n;
		for (n = 0; n < count; n++)
			send_word(pick_word());
	endtask

	// stimulus
	initial begin : stimulus
		tracker = new(TABLE_DEPTH);
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of the fields at the reset limit, near misses in ip and port
		send_peer(32'h0000_0000, 16'h0000, 32'h0000_0000);
		send_peer(32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF);
		send_peer(32'h0000_0000, 16'h0000, 32'hFFFF_FFFF);
		send_peer(32'h0000_0000, 16'h0001, 32'h0000_0001);
		send_peer(32'h0000_0001, 16'h0000, 32'h7FFF_FFFF);
		send_peer(32'h8000_0000, 16'h8000, 32'h8000_0000);
		send_peer(32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000);

		// zero limit below the occupancy: known peers refresh, new ones rejected
		set_peer_limit(5'd0);
		send_peer(32'hC0A8_0001, 16'd8080, 32'h1234_5678);
		send_peer(32'h8000_0000, 16'h8000, 32'hFFFF_FFFE);
		send_peer(32'hFFFF_FFFE, 16'hFFFF, 32'h0000_0002);
		run_random(150);

		set_peer_limit(5'd7);
		run_random(200);

		// limit lowered below the occupancy
		set_peer_limit(5'd3);
		run_random(150);

		// long stretch without idling on either side
		set_peer_limit(5'd12);
		calm = 1'b1;
		run_random(250);
		calm = 1'b0;

		// largest writable value saturates to the depth
		set_peer_limit(5'd31);
		run_random(300);

		set_peer_limit(5'd20);
		run_random(150);

		set_peer_limit(5'd16);
		run_random(150);

		// drain, then give stray words time to show up
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE * 2) @(posedge clk);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
